@@ design/ru_sps_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RU slot packet selector package
// Shared types, constants and a helper function.
// ----------------------------------------------------------------------------
package ru_sps_pkg;

  localparam int TOTAL_SLOTS        = 33;
  localparam int IDX_W              = $clog2(TOTAL_SLOTS);
  localparam int CNT_W              = $clog2(TOTAL_SLOTS + 1);
  localparam int DEADLINE_FRAC_BITS = 4;
  localparam int NUM_MODES          = 5;
  localparam int LIM_W              = 24;
  localparam int K_W                = 18;
  localparam int PROD_W             = LIM_W + K_W;

  localparam logic [2:0] KIND_PLACED  = 3'd0;
  localparam logic [2:0] KIND_EVICTED = 3'd1;
  localparam logic [2:0] KIND_REJECT  = 3'd2;
  localparam logic [2:0] KIND_KEPT    = 3'd3;
  localparam logic [2:0] KIND_SUMMARY = 3'd4;

  localparam logic [2:0] MODE_RU484 = 3'd0;
  localparam logic [2:0] MODE_RU242 = 3'd1;
  localparam logic [2:0] MODE_RU106 = 3'd2;
  localparam logic [2:0] MODE_RU52  = 3'd3;
  localparam logic [2:0] MODE_RU26  = 3'd4;

  localparam logic [2:0] REG_START = 3'd0;
  localparam logic [2:0] REG_END   = 3'd1;
  localparam logic [2:0] REG_S484  = 3'd2;
  localparam logic [2:0] REG_S242  = 3'd3;
  localparam logic [2:0] REG_S106  = 3'd4;
  localparam logic [2:0] REG_S52   = 3'd5;
  localparam logic [2:0] REG_S26   = 3'd6;
  localparam logic [2:0] REG_BEAT  = 3'd7;

  typedef struct packed {
    logic        action;
    logic [15:0] packet_id;
    logic [15:0] penalty;
    logic [15:0] arrival;
    logic [15:0] data_size;
    logic [23:0] deadline_q;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  mode;
    logic [15:0] out_packet_id;
    logic [15:0] out_penalty;
    logic [21:0] score;
    logic        beats_best;
    logic        last;
    logic        free_ru484;
    logic [1:0]  free_ru242;
    logic [2:0]  free_ru106;
    logic [3:0]  free_ru52;
    logic [4:0]  free_ru26;
  } out_item_t;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] pen;
    logic [2:0]  mode;
  } entry_t;

  typedef struct packed {
    logic [15:0]                ivl_start;
    logic [15:0]                ivl_end;
    logic [NUM_MODES-1:0][4:0]  slots;
    logic signed [22:0]         score_to_beat;
  } cfg_t;

  // 100 x rate in tenths of Mbps, per unit size
  function automatic logic [K_W-1:0] rate_k(input logic [2:0] m);
    logic [K_W-1:0] k;
    case (m)
      MODE_RU484: k = K_W'(243800);
      MODE_RU242: k = K_W'(121900);
      MODE_RU106: k = K_W'(47200);
      MODE_RU52:  k = K_W'(22200);
      MODE_RU26:  k = K_W'(11100);
      default:    k = '0;
    endcase
    return k;
  endfunction

endpackage

@@ design/ru_slot_packet_selector_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RU slot packet selector
// Places offered packets on resource units and lists the selection.
// ----------------------------------------------------------------------------
//  channel | ports                                  | moves
//  --------+----------------------------------------+---------------------------
//  input   | in_valid, in_ready, in_data            | one offer or finish item
//  output  | out_valid, out_ready, out_data         | results, last marks the end
//  config  | psel, penable, pwrite, paddr, pwdata,  | registers at 4*index
//          | prdata, pready                         |
//
// One item at a time; in_ready is high only while the sequencer is idle. An
// offer skips a size without slots and runs a fit check on a size that is
// tried; a full size adds a scan of the stored entries and a decision, and
// an eviction a compaction pass over the later entries and a write-back.
// Finish steps through each size and, per kept packet, scans the store and
// lists the lowest-penalty unlisted one. The slot store has one read port.
// Reset is synchronous; no clearing pass. Output stalls hold the sequencer.
// ----------------------------------------------------------------------------
module ru_slot_packet_selector_top (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ru_sps_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ru_sps_pkg::out_item_t out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [4:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import ru_sps_pkg::*;

  cfg_t      cfg_r;
  logic      out_valid_r;
  out_item_t out_data_r;
  logic      emit_valid;
  logic      emit_ready;
  out_item_t emit_data;
  logic      wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ivl_start     <= 16'd0;
      cfg_r.ivl_end       <= 16'd1;
      cfg_r.slots         <= {{(NUM_MODES-1){5'd0}}, 5'd1};
      cfg_r.score_to_beat <= -23'sd1;
    end else if (wr_en) begin
      case (paddr[4:2])
        REG_START: cfg_r.ivl_start     <= pwdata[15:0];
        REG_END:   cfg_r.ivl_end       <= pwdata[15:0];
        REG_S484:  cfg_r.slots[0]      <= {4'd0, pwdata[0]};
        REG_S242:  cfg_r.slots[1]      <= {3'd0, pwdata[1:0]};
        REG_S106:  cfg_r.slots[2]      <= {2'd0, pwdata[2:0]};
        REG_S52:   cfg_r.slots[3]      <= {1'd0, pwdata[3:0]};
        REG_S26:   cfg_r.slots[4]      <= pwdata[4:0];
        REG_BEAT:  cfg_r.score_to_beat <= $signed(pwdata[22:0]);
        default:   cfg_r.ivl_start     <= cfg_r.ivl_start;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_START: prdata = 32'(cfg_r.ivl_start);
      REG_END:   prdata = 32'(cfg_r.ivl_end);
      REG_S484:  prdata = 32'(cfg_r.slots[0]);
      REG_S242:  prdata = 32'(cfg_r.slots[1]);
      REG_S106:  prdata = 32'(cfg_r.slots[2]);
      REG_S52:   prdata = 32'(cfg_r.slots[3]);
      REG_S26:   prdata = 32'(cfg_r.slots[4]);
      REG_BEAT:  prdata = 32'(unsigned'(cfg_r.score_to_beat));
      default:   prdata = '0;
    endcase
  end

  ru_sps_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .cfg        (cfg_r),
    .emit_valid (emit_valid),
    .emit_ready (emit_ready),
    .emit_data  (emit_data)
  );

  // output register: take a new item when empty or being drained
  assign emit_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_ready) begin
      out_valid_r <= emit_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_ready && emit_valid) begin
      out_data_r <= emit_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ design/ru_sps_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ru_sps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/ru_sps_fit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RU fit check
// Registered product of rate and time budget, compared against the payload.
// ----------------------------------------------------------------------------
module ru_sps_fit (
  input  logic               clk,
  input  logic [2:0]         mode,
  input  ru_sps_pkg::cfg_t   cfg,
  input  ru_sps_pkg::in_item_t item,
  output logic               fit
);
  import ru_sps_pkg::*;

  logic [LIM_W-1:0]  start_q;
  logic [LIM_W-1:0]  end_q;
  logic [LIM_W-1:0]  lim;
  logic [PROD_W-1:0] prod_r;
  logic              ok_r;
  logic [PROD_W-1:0] need;

  assign start_q = LIM_W'(cfg.ivl_start) << DEADLINE_FRAC_BITS;
  assign end_q   = LIM_W'(cfg.ivl_end) << DEADLINE_FRAC_BITS;
  assign lim     = (item.deadline_q < end_q) ? item.deadline_q : end_q;

  always_ff @(posedge clk) begin
    ok_r   <= (item.arrival <= cfg.ivl_start) && (start_q <= lim);
    prod_r <= PROD_W'(rate_k(mode)) * PROD_W'(lim - start_q);
  end

  // bits * 2^frac, compared against rate * (limit - start)
  assign need = PROD_W'(item.data_size) << (3 + DEADLINE_FRAC_BITS);
  assign fit  = ok_r && (prod_r >= need);

endmodule

@@ design/ru_sps_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RU selector sequencer
// Scans the slot store, places, rejects, evicts, compacts and lists kept packets.
// ----------------------------------------------------------------------------
module ru_sps_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ru_sps_pkg::in_item_t  in_data,
  input  ru_sps_pkg::cfg_t      cfg,
  output logic                  emit_valid,
  input  logic                  emit_ready,
  output ru_sps_pkg::out_item_t emit_data
);
  import ru_sps_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_TRY    = 4'd1;
  localparam logic [3:0] ST_FCMP   = 4'd2;
  localparam logic [3:0] ST_SCAN   = 4'd3;
  localparam logic [3:0] ST_OFFDEC = 4'd4;
  localparam logic [3:0] ST_PLACE  = 4'd5;
  localparam logic [3:0] ST_EVICT  = 4'd6;
  localparam logic [3:0] ST_SHIFT  = 4'd7;
  localparam logic [3:0] ST_EVWR   = 4'd8;
  localparam logic [3:0] ST_REJ    = 4'd9;
  localparam logic [3:0] ST_LSTART = 4'd10;
  localparam logic [3:0] ST_LEMIT  = 4'd11;
  localparam logic [3:0] ST_SUM    = 4'd12;

  logic [3:0]                state_r;
  in_item_t                  item_r;
  logic [2:0]                mode_r;
  logic [4:0]                n_r;
  logic [NUM_MODES-1:0][4:0] counts_r;
  logic [21:0]               score_r;
  logic [CNT_W-1:0]          ins_r;
  logic [TOTAL_SLOTS-1:0]    listed_r;
  logic [CNT_W-1:0]          idx_r;
  logic                      rdv_r;
  logic [IDX_W-1:0]          rdidx_r;
  logic                      found_r;
  logic [IDX_W-1:0]          best_idx_r;
  logic [15:0]               best_pen_r;
  logic [15:0]               best_id_r;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  entry_t           ram_rdata;
  logic             rd_issue;
  logic             hit;
  logic             scan_done;
  logic             fit;
  logic [4:0]       cap;
  logic [4:0]       cnt;
  logic [21:0]      score_evict;
  logic [NUM_MODES-1:0][4:0] free_v;

  ru_sps_ram #(.WIDTH($bits(entry_t)), .DEPTH(TOTAL_SLOTS)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  ru_sps_fit u_fit (
    .clk  (clk),
    .mode (mode_r),
    .cfg  (cfg),
    .item (item_r),
    .fit  (fit)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign cap       = (mode_r < 3'(NUM_MODES)) ? cfg.slots[mode_r] : 5'd0;
  assign cnt       = (mode_r < 3'(NUM_MODES)) ? counts_r[mode_r] : 5'd0;
  assign rd_issue  = ((state_r == ST_SCAN) || (state_r == ST_SHIFT)) && (idx_r < ins_r);
  assign scan_done = (idx_r >= ins_r) && !rdv_r;
  assign hit = rdv_r && (state_r == ST_SCAN) && (ram_rdata.mode == mode_r) &&
               !(item_r.action && listed_r[rdidx_r]) &&
               (!found_r || (ram_rdata.pen < best_pen_r));
  assign score_evict = score_r + 22'(item_r.penalty) - 22'(best_pen_r);

  always_comb begin
    for (int m = 0; m < NUM_MODES; m++) begin
      free_v[m] = (counts_r[m] < cfg.slots[m]) ? cfg.slots[m] - counts_r[m] : 5'd0;
    end
  end

  // store writes: compaction moves entries down, then new packets append
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ins_r[IDX_W-1:0];
    ram_wdata = '{id: item_r.packet_id, pen: item_r.penalty, mode: mode_r};
    case (state_r)
      ST_PLACE: ram_we = emit_ready;
      ST_SHIFT: begin
        ram_we    = rdv_r;
        ram_waddr = rdidx_r - IDX_W'(1);
        ram_wdata = ram_rdata;
      end
      ST_EVWR: begin
        ram_we    = 1'b1;
        ram_waddr = IDX_W'(ins_r - CNT_W'(1));
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_comb begin
    emit_valid = 1'b0;
    emit_data  = '0;
    emit_data.last  = 1'b1;
    emit_data.score = score_r;
    case (state_r)
      ST_PLACE: begin
        emit_valid              = 1'b1;
        emit_data.kind          = KIND_PLACED;
        emit_data.mode          = mode_r;
        emit_data.out_packet_id = item_r.packet_id;
        emit_data.out_penalty   = item_r.penalty;
        emit_data.score         = score_r + 22'(item_r.penalty);
      end
      ST_EVICT: begin
        emit_valid              = 1'b1;
        emit_data.kind          = KIND_EVICTED;
        emit_data.mode          = mode_r;
        emit_data.out_packet_id = best_id_r;
        emit_data.out_penalty   = best_pen_r;
        emit_data.score         = score_evict;
      end
      ST_REJ: begin
        emit_valid              = 1'b1;
        emit_data.kind          = KIND_REJECT;
        emit_data.out_packet_id = item_r.packet_id;
        emit_data.out_penalty   = item_r.penalty;
      end
      ST_LEMIT: begin
        emit_valid              = found_r;
        emit_data.kind          = KIND_KEPT;
        emit_data.mode          = mode_r;
        emit_data.out_packet_id = best_id_r;
        emit_data.out_penalty   = best_pen_r;
        emit_data.last          = 1'b0;
      end
      ST_SUM: begin
        emit_valid           = 1'b1;
        emit_data.kind       = KIND_SUMMARY;
        emit_data.beats_best = $signed({1'b0, score_r}) >= cfg.score_to_beat;
        emit_data.free_ru484 = free_v[0][0];
        emit_data.free_ru242 = free_v[1][1:0];
        emit_data.free_ru106 = free_v[2][2:0];
        emit_data.free_ru52  = free_v[3][3:0];
        emit_data.free_ru26  = free_v[4];
      end
      default: emit_valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      counts_r <= '0;
      score_r  <= '0;
      ins_r    <= '0;
      listed_r <= '0;
      rdv_r    <= 1'b0;
      idx_r    <= '0;
      found_r  <= 1'b0;
      mode_r   <= '0;
      n_r      <= '0;
    end else begin
      rdv_r   <= rd_issue;
      rdidx_r <= idx_r[IDX_W-1:0];
      if (rd_issue) begin
        idx_r <= idx_r + CNT_W'(1);
      end
      if (hit) begin
        found_r    <= 1'b1;
        best_idx_r <= rdidx_r;
        best_pen_r <= ram_rdata.pen;
        best_id_r  <= ram_rdata.id;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            item_r <= in_data;
            n_r    <= '0;
            if (in_data.action) begin
              mode_r  <= MODE_RU484;
              state_r <= ST_LSTART;
            end else begin
              mode_r  <= MODE_RU26;
              state_r <= ST_TRY;
            end
          end
        end
        ST_TRY: begin
          if (cap != 5'd0) begin
            state_r <= ST_FCMP;
          end else if (mode_r == MODE_RU484) begin
            state_r <= ST_REJ;
          end else begin
            mode_r <= mode_r - 3'd1;
          end
        end
        ST_FCMP: begin
          if (!fit) begin
            if (mode_r == MODE_RU484) begin
              state_r <= ST_REJ;
            end else begin
              mode_r  <= mode_r - 3'd1;
              state_r <= ST_TRY;
            end
          end else if ((cnt < cap) && (ins_r < CNT_W'(TOTAL_SLOTS))) begin
            state_r <= ST_PLACE;
          end else begin
            idx_r   <= '0;
            found_r <= 1'b0;
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_done) begin
            state_r <= item_r.action ? ST_LEMIT : ST_OFFDEC;
          end
        end
        ST_OFFDEC: begin
          if (found_r && (best_pen_r < item_r.penalty)) begin
            state_r <= ST_EVICT;
          end else if (mode_r == MODE_RU484) begin
            state_r <= ST_REJ;
          end else begin
            mode_r  <= mode_r - 3'd1;
            state_r <= ST_TRY;
          end
        end
        ST_EVICT: begin
          if (emit_ready) begin
            score_r <= score_evict;
            idx_r   <= CNT_W'(best_idx_r) + CNT_W'(1);
            state_r <= ST_SHIFT;
          end
        end
        ST_SHIFT: begin
          if (scan_done) begin
            state_r <= ST_EVWR;
          end
        end
        ST_EVWR: state_r <= ST_IDLE;
        ST_PLACE: begin
          if (emit_ready) begin
            ins_r            <= ins_r + CNT_W'(1);
            counts_r[mode_r] <= cnt + 5'd1;
            score_r          <= score_r + 22'(item_r.penalty);
            state_r          <= ST_IDLE;
          end
        end
        ST_REJ: begin
          if (emit_ready) begin
            state_r <= ST_IDLE;
          end
        end
        ST_LSTART: begin
          if (mode_r == 3'(NUM_MODES)) begin
            state_r <= ST_SUM;
          end else if (n_r < cnt) begin
            idx_r   <= '0;
            found_r <= 1'b0;
            state_r <= ST_SCAN;
          end else begin
            mode_r <= mode_r + 3'd1;
            n_r    <= '0;
          end
        end
        ST_LEMIT: begin
          if (!found_r) begin
            mode_r  <= mode_r + 3'd1;
            n_r     <= '0;
            state_r <= ST_LSTART;
          end else if (emit_ready) begin
            listed_r[best_idx_r] <= 1'b1;
            n_r                  <= n_r + 5'd1;
            state_r              <= ST_LSTART;
          end
        end
        ST_SUM: begin
          if (emit_ready) begin
            counts_r <= '0;
            score_r  <= '0;
            ins_r    <= '0;
            listed_r <= '0;
            state_r  <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ design/ru_sps_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RU selector port checker
// Port-level properties of the selector, bound to the top level.
// ----------------------------------------------------------------------------
module ru_sps_chk (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input ru_sps_pkg::out_item_t out_data
);
  import ru_sps_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in work");

  a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == KIND_SUMMARY) |-> out_data.last)
    else $error("summary without last");

  a_offer_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_data.kind == KIND_PLACED) || (out_data.kind == KIND_EVICTED) ||
                  (out_data.kind == KIND_REJECT))
    |-> out_data.last && !out_data.beats_best)
    else $error("offer result malformed");

endmodule

bind ru_slot_packet_selector_top ru_sps_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

@@ test/tb_ru_slot_packet_selector_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RU slot packet selector testbench
// Offers packets and finish items through a valid/ready channel, and checks
// every result against a behavioral placement model with its own copy of the
// slot store. Registers are written between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_ru_slot_packet_selector_top;
  import ru_sps_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 200;
  localparam int NUM_RANDOM     = 345;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ru_slot_packet_selector_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Model state: register copies and the kept-packet store
  logic [15:0]        m_start;
  logic [15:0]        m_end;
  logic [4:0]         m_slots [NUM_MODES];
  logic [22:0]        m_beat;
  entry_t             kept_q [$];
  int unsigned        kept_cnt [NUM_MODES];
  logic [21:0]        m_score;

  out_item_t          pending_q [$];
  int                 errors;
  int                 idle_cycles;
  int                 results_seen;
  int                 items_sent;
  int                 finishes_sent;
  bit                 hold_off;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [4:0] slot_width_mask(int m);
    case (m)
      0: return 5'h01;
      1: return 5'h03;
      2: return 5'h07;
      3: return 5'h0F;
      default: return 5'h1F;
    endcase
  endfunction

  function automatic longint unsigned rate_tenths(int m);
    case (m)
      0: return 2438;
      1: return 1219;
      2: return 472;
      3: return 222;
      default: return 111;
    endcase
  endfunction

  function automatic bit size_fits(int m, in_item_t it);
    longint unsigned lim, lhs, rhs, r;
    r = rate_tenths(m);
    if (it.arrival > m_start) return 1'b0;
    lim = longint'(m_end) << DEADLINE_FRAC_BITS;
    if (it.deadline_q < lim) lim = it.deadline_q;
    lhs = ((longint'(m_start) << DEADLINE_FRAC_BITS) * 100 * r)
        + ((longint'(it.data_size) * 8) << DEADLINE_FRAC_BITS);
    rhs = lim * 100 * r;
    return lhs <= rhs;
  endfunction

  function automatic out_item_t blank_result(logic [2:0] kind, logic [2:0] mode,
                                             logic [15:0] id, logic [15:0] pen);
    out_item_t r;
    r = '0;
    r.kind = kind;
    r.mode = mode;
    r.out_packet_id = id;
    r.out_penalty = pen;
    r.score = m_score;
    r.last = 1'b1;
    return r;
  endfunction

  // Queue one expected result behind the ones already waiting
  function automatic void queue_result(out_item_t r);
    pending_q = {pending_q, r};
  endfunction

  function automatic void place_packet(logic [15:0] id, logic [15:0] pen, int m);
    entry_t e;
    if (kept_q.size() >= TOTAL_SLOTS) return;
    e.id = id;
    e.pen = pen;
    e.mode = 3'(m);
    kept_q = {kept_q, e};
    kept_cnt[m]++;
    m_score = m_score + 22'(pen);
  endfunction

  // Compute the results of one input item and advance the model
  function automatic void predict_selection(in_item_t it);
    out_item_t r;
    int best;
    entry_t gone;
    int unsigned freev [NUM_MODES];
    bit listed [$];
    logic signed [22:0] target;
    if (!it.action) begin
      for (int m = NUM_MODES - 1; m >= 0; m--) begin
        if (m_slots[m] == 0 || !size_fits(m, it)) continue;
        if (kept_cnt[m] < m_slots[m] && kept_q.size() < TOTAL_SLOTS) begin
          place_packet(it.packet_id, it.penalty, m);
          queue_result(blank_result(KIND_PLACED, 3'(m), it.packet_id, it.penalty));
          return;
        end
        best = -1;
        foreach (kept_q[i]) begin
          if (kept_q[i].mode != 3'(m)) continue;
          if (best < 0 || kept_q[i].pen < kept_q[best].pen) best = i;
        end
        if (best >= 0 && kept_q[best].pen < it.penalty) begin
          gone = kept_q[best];
          kept_q.delete(best);
          kept_cnt[m]--;
          m_score = m_score - 22'(gone.pen);
          place_packet(it.packet_id, it.penalty, m);
          queue_result(blank_result(KIND_EVICTED, 3'(m), gone.id, gone.pen));
          return;
        end
      end
      queue_result(blank_result(KIND_REJECT, MODE_RU484, it.packet_id, it.penalty));
    end else begin
      foreach (kept_q[i]) listed = {listed, 1'b0};
      for (int m = 0; m < NUM_MODES; m++) begin
        freev[m] = (kept_cnt[m] < m_slots[m]) ? m_slots[m] - kept_cnt[m] : 0;
        for (int n = 0; n < kept_cnt[m]; n++) begin
          best = -1;
          foreach (kept_q[i]) begin
            if (listed[i] || kept_q[i].mode != 3'(m)) continue;
            if (best < 0 || kept_q[i].pen < kept_q[best].pen) best = i;
          end
          if (best < 0) break;
          listed[best] = 1'b1;
          r = blank_result(KIND_KEPT, 3'(m), kept_q[best].id, kept_q[best].pen);
          r.last = 1'b0;
          queue_result(r);
        end
      end
      target = m_beat;
      r = blank_result(KIND_SUMMARY, MODE_RU484, 16'd0, 16'd0);
      r.beats_best = ($signed({1'b0, m_score}) >= target);
      r.free_ru484 = 1'(freev[0]);
      r.free_ru242 = 2'(freev[1]);
      r.free_ru106 = 3'(freev[2]);
      r.free_ru52 = 4'(freev[3]);
      r.free_ru26 = 5'(freev[4]);
      queue_result(r);
      kept_q.delete();
      foreach (kept_cnt[m]) kept_cnt[m] = 0;
      m_score = '0;
    end
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("[%0t] %s: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  // Result side: random stalls, a long hold-off on request, checks
  initial begin
    int gap;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_ready = 1'b0;
        repeat (400) @(negedge clk);
        hold_off = 1'b0;
      end
      gap = ($urandom_range(0, 9) < 6) ? 0 :
            (($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 30));
      if (gap != 0 && $urandom_range(0, 3) != 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result kind", out_data.kind, 0);
      end else begin
        want = pending_q.pop_front();
        if (out_data.kind !== want.kind) report_mismatch("kind", out_data.kind, want.kind);
        if (out_data.mode !== want.mode) report_mismatch("mode", out_data.mode, want.mode);
        if (out_data.out_packet_id !== want.out_packet_id)
          report_mismatch("packet_id", out_data.out_packet_id, want.out_packet_id);
        if (out_data.out_penalty !== want.out_penalty)
          report_mismatch("penalty", out_data.out_penalty, want.out_penalty);
        if (out_data.score !== want.score) report_mismatch("score", out_data.score, want.score);
        if (out_data.beats_best !== want.beats_best)
          report_mismatch("beats_best", out_data.beats_best, want.beats_best);
        if (out_data.last !== want.last) report_mismatch("last", out_data.last, want.last);
        if (out_data.free_ru484 !== want.free_ru484)
          report_mismatch("free_ru484", out_data.free_ru484, want.free_ru484);
        if (out_data.free_ru242 !== want.free_ru242)
          report_mismatch("free_ru242", out_data.free_ru242, want.free_ru242);
        if (out_data.free_ru106 !== want.free_ru106)
          report_mismatch("free_ru106", out_data.free_ru106, want.free_ru106);
        if (out_data.free_ru52 !== want.free_ru52)
          report_mismatch("free_ru52", out_data.free_ru52, want.free_ru52);
        if (out_data.free_ru26 !== want.free_ru26)
          report_mismatch("free_ru26", out_data.free_ru26, want.free_ru26);
      end
    end
  end

  // Watchdog: cycles with no handshake on any channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired, %0d results still pending", pending_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    case (idx)
      REG_START: m_start = value[15:0];
      REG_END:   m_end = value[15:0];
      REG_BEAT:  m_beat = value[22:0];
      default:   m_slots[idx - REG_S484] = value[4:0] & slot_width_mask(idx - REG_S484);
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_item(in_item_t it, int gap);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_selection(it);
    items_sent++;
    if (it.action) finishes_sent++;
    // drop valid so the item is not taken twice
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  function automatic int random_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic in_item_t mk_item(bit act, int id, int pen, int arr, int sz, int dq);
    in_item_t it;
    it.action = act;
    it.packet_id = 16'(id);
    it.penalty = 16'(pen);
    it.arrival = 16'(arr);
    it.data_size = 16'(sz);
    it.deadline_q = 24'(dq);
    return it;
  endfunction

  // Offer that usually fits the current interval, with random content
  function automatic in_item_t fitting_offer();
    in_item_t it;
    it = mk_item(1'b0, $urandom, $urandom_range(0, 99) < 10 ? $urandom : $urandom_range(0, 300),
                 $urandom_range(0, m_start), $urandom_range(0, 99) < 10 ? $urandom :
                 $urandom_range(0, 2000), $urandom_range(0, 99) < 15 ? $urandom :
                 (int'(m_end) << DEADLINE_FRAC_BITS) + $urandom_range(0, 64));
    return it;
  endfunction

  typedef struct {
    in_item_t    item;
    bit          typed;
    logic [2:0]  kind;
    logic [2:0]  mode;
  } directed_row_t;

  directed_row_t directed [];

  initial begin
    in_item_t it;
    int unsigned cfg_phase;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    hold_off = 1'b0;
    errors = 0;
    idle_cycles = 0;
    results_seen = 0;
    items_sent = 0;
    finishes_sent = 0;
    m_start = 16'd0;
    m_end = 16'd1;
    m_slots = '{5'd1, 5'd0, 5'd0, 5'd0, 5'd0};
    m_beat = 23'h7FFFFF;
    m_score = '0;
    foreach (kept_cnt[m]) kept_cnt[m] = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // After reset: only one ru484 slot over [0,1] ms
    directed = new[6];
    directed[0] = '{mk_item(1'b1, 0, 0, 0, 0, 0), 1'b1, KIND_SUMMARY, MODE_RU484};
    directed[1] = '{mk_item(1'b0, 16'h0001, 5, 0, 0, 16), 1'b1, KIND_PLACED, MODE_RU484};
    directed[2] = '{mk_item(1'b0, 16'h0002, 5, 0, 0, 16), 1'b1, KIND_REJECT, MODE_RU484};
    directed[3] = '{mk_item(1'b0, 16'hFFFF, 16'hFFFF, 0, 0, 24'hFFFFFF), 1'b1,
                    KIND_EVICTED, MODE_RU484};
    directed[4] = '{mk_item(1'b0, 16'h0003, 9, 16'hFFFF, 0, 16), 1'b1, KIND_REJECT, MODE_RU484};
    directed[5] = '{mk_item(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF), 1'b0,
                    KIND_SUMMARY, MODE_RU484};
    foreach (directed[i]) begin
      send_item(directed[i].item, random_gap());
      if (directed[i].typed && (pending_q[$].kind !== directed[i].kind ||
                                pending_q[$].mode !== directed[i].mode))
        report_mismatch("directed row prediction", pending_q[$].kind, directed[i].kind);
    end
    wait_idle();

    // Full configuration, interval end at its top and slots for every size
    write_reg(REG_START, 32'd100);
    write_reg(REG_END, 32'hFFFF);
    write_reg(REG_S484, 32'd1);
    write_reg(REG_S242, 32'd2);
    write_reg(REG_S106, 32'd4);
    write_reg(REG_S52, 32'd8);
    write_reg(REG_S26, 32'd18);
    write_reg(REG_BEAT, 32'h3FFFFF);
    directed = new[15];
    directed[0] = '{mk_item(1'b0, 10, 7, 0, 0, 0), 1'b1, KIND_REJECT, MODE_RU484};
    directed[1] = '{mk_item(1'b0, 11, 7, 100, 0, 1600), 1'b1, KIND_PLACED, MODE_RU26};
    directed[2] = '{mk_item(1'b0, 12, 7, 101, 0, 1600), 1'b1, KIND_REJECT, MODE_RU484};
    directed[3] = '{mk_item(1'b0, 13, 3, 0, 16'hFFFF, 24'hFFFFFF), 1'b0,
                    KIND_PLACED, MODE_RU484};
    directed[4] = '{mk_item(1'b0, 14, 0, 50, 2000, 24'h100000), 1'b0,
                    KIND_PLACED, MODE_RU484};
    for (int i = 5; i < 14; i++)
      directed[i] = '{mk_item(1'b0, 20 + i, i, 10, 100 * i, 24'h0FFFFF), 1'b0,
                      KIND_PLACED, MODE_RU484};
    directed[14] = '{mk_item(1'b1, 0, 0, 0, 0, 0), 1'b0, KIND_SUMMARY, MODE_RU484};
    foreach (directed[i]) begin
      send_item(directed[i].item, random_gap());
      if (directed[i].typed && (pending_q[$].kind !== directed[i].kind ||
                                pending_q[$].mode !== directed[i].mode))
        report_mismatch("directed row prediction", pending_q[$].kind, directed[i].kind);
    end
    wait_idle();

    // Random phases, each with its own register setting
    cfg_phase = 0;
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n % 40 == 0) begin
        wait_idle();
        cfg_phase++;
        write_reg(REG_START, (cfg_phase % 4 == 0) ? 32'hFFFF : $urandom_range(0, 1000));
        write_reg(REG_END, (cfg_phase % 5 == 0) ? 32'd0 : $urandom_range(m_start, 16'hFFFF));
        write_reg(REG_S484, $urandom);
        write_reg(REG_S242, (cfg_phase % 3 == 0) ? 32'd0 : $urandom_range(0, 3));
        write_reg(REG_S106, $urandom_range(0, 7));
        write_reg(REG_S52, (cfg_phase % 2 == 0) ? 32'd8 : $urandom_range(0, 15));
        write_reg(REG_S26, (cfg_phase % 3 == 1) ? 32'd31 : $urandom_range(0, 18));
        write_reg(REG_BEAT, (cfg_phase % 3 == 0) ? 32'h400000 : $urandom_range(0, 5000));
      end
      if (n == 120) hold_off = 1'b1;
      if (n == 200) wait_idle();
      if ($urandom_range(0, 99) < 8)
        it = mk_item(1'b1, $urandom, $urandom, $urandom, $urandom, $urandom);
      else if ($urandom_range(0, 99) < 80)
        it = fitting_offer();
      else
        it = mk_item(1'b0, $urandom, $urandom, $urandom, $urandom, $urandom);
      send_item(it, random_gap());
    end
    // Lower slots below the kept count before the last listing
    wait_idle();
    write_reg(REG_S26, 32'd0);
    write_reg(REG_S52, 32'd1);
    send_item(mk_item(1'b1, 0, 0, 0, 0, 0), 0);
    @(negedge clk);
    in_valid = 1'b0;

    wait_idle();
    $display("Sent %0d items (%0d finishes) over %0d register settings; %0d results checked.",
             items_sent, finishes_sent, cfg_phase + 2, results_seen);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", errors);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
